### rtl/thdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package thdl_pkg;

  localparam int KEY_W = 28;
  localparam int VAL_W = 32;
  localparam int IDX_W = 6;
  localparam int STAT_W = 2;

  // register byte addresses
  localparam logic [1:0] REG_TABLE_SIZE = 2'd0;

  // delimiters and number characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // number parse phase
  localparam logic [1:0] PH_EXPECT = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // lookup status
  localparam logic [STAT_W-1:0] LK_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] LK_MISS  = 2'd1;
  localparam logic [STAT_W-1:0] LK_EMPTY = 2'd2;

  localparam logic [35:0] LIMIT_POS = 36'h07FFFFFFF;
  localparam logic [35:0] LIMIT_NEG = 36'h080000000;

  typedef struct packed {
    logic             in_token;
    logic [KEY_W-1:0] hash;
    logic [VAL_W-1:0] value;
  } token_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  index;
    logic [KEY_W-1:0]  hash;
  } result_t;

  function automatic logic [KEY_W-1:0] elf_step(input logic [KEY_W-1:0] h,
                                                input logic [7:0] b);
    logic [31:0] s;
    s = {h, 4'b0000} + {24'd0, b};
    return s[27:0] ^ {20'd0, s[31:28], 4'b0000};
  endfunction

endpackage

`default_nettype wire

### rtl/thdl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module thdl_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/thdl_token.sv
`timescale 1ns / 1ps
`default_nettype none

module thdl_token import thdl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_en,
  input  wire logic       clear,
  input  wire logic [7:0] data_byte,
  output token_t          tok
);

  logic [KEY_W-1:0] hash_acc;
  logic             in_token;
  logic [31:0]      number_acc;
  logic [1:0]       number_phase;
  logic             is_negative;

  logic [31:0] number_acc_next;
  logic [1:0]  number_phase_next;
  logic        is_negative_next;
  logic        digit;
  logic        accum;
  logic [35:0] prod;
  logic [35:0] limit;

  always_comb begin
    digit = data_byte inside {[CH_ZERO:CH_NINE]};
    limit = is_negative ? LIMIT_NEG : LIMIT_POS;
    prod = ({4'd0, number_acc} << 3) + ({4'd0, number_acc} << 1)
           + {32'd0, data_byte[3:0]};
    number_phase_next = number_phase;
    is_negative_next = is_negative;
    accum = 1'b0;
    case (number_phase)
      PH_EXPECT: begin
        if (data_byte inside {CH_TAB, CH_VT, CH_FF}) begin
          number_phase_next = number_phase;
        end else if (data_byte inside {CH_PLUS, CH_MINUS}) begin
          is_negative_next = (data_byte == CH_MINUS);
          number_phase_next = PH_DIGITS;
        end else if (!digit) begin
          number_phase_next = PH_DONE;
        end else begin
          number_phase_next = PH_DIGITS;
          accum = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          accum = 1'b1;
        end else begin
          number_phase_next = PH_DONE;
        end
      end
      default: begin
        number_phase_next = number_phase;
      end
    endcase
    number_acc_next = number_acc;
    if (accum) begin
      number_acc_next = (prod > limit) ? limit[31:0] : prod[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hash_acc <= '0;
      in_token <= 1'b0;
      number_acc <= '0;
      number_phase <= PH_EXPECT;
      is_negative <= 1'b0;
    end else if (byte_en) begin
      hash_acc <= elf_step(hash_acc, data_byte);
      in_token <= 1'b1;
      number_acc <= number_acc_next;
      number_phase <= number_phase_next;
      is_negative <= is_negative_next;
    end
  end

  always_comb begin
    tok.in_token = in_token;
    tok.hash = hash_acc;
    tok.value = is_negative ? (32'd0 - number_acc) : number_acc;
  end

endmodule

`default_nettype wire

### rtl/thdl_search.sv
`timescale 1ns / 1ps
`default_nettype none

module thdl_search import thdl_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire token_t                   tok,
  input  wire logic                     line_in,
  input  wire logic [6:0]               table_size,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [KEY_W-1:0]         wr_key,
  output logic                          busy,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output result_t                       out_data,
  output logic                          out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = (AW + 1 > 7) ? AW + 1 : 7;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_DONE} state_t;

  state_t            state;
  logic [AW-1:0]     lo;
  logic [AW-1:0]     hi;
  logic [AW-1:0]     mid_r;
  logic [KEY_W-1:0]  hash_r;
  logic [VAL_W-1:0]  value_r;
  logic              line_r;
  logic [STAT_W-1:0] status_r;
  logic [AW-1:0]     index_r;

  logic [NW-1:0]     n_ext;
  logic [NW-1:0]     n_sat;
  logic [NW-1:0]     n_last;
  logic [AW:0]       mid_sum;
  logic [AW-1:0]     mid;
  logic [KEY_W-1:0]  rdata;
  logic [NW-1:0]     index_ext;
  logic              out_free;

  always_comb begin
    n_ext = NW'(table_size);
    n_sat = (n_ext > NW'(DEPTH)) ? NW'(DEPTH) : n_ext;
    n_last = n_sat - NW'(1);
    mid_sum = {1'b0, lo} + {1'b0, hi};
    mid = mid_sum[AW:1];
    index_ext = NW'(index_r);
    out_free = !out_valid || out_ready;
    busy = (state != S_IDLE);
  end

  thdl_ram #(
    .WIDTH(KEY_W),
    .DEPTH(DEPTH)
  ) u_keys (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_key),
    .re   (state == S_READ),
    .raddr(mid),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            hash_r <= tok.hash;
            value_r <= tok.value;
            line_r <= line_in;
            index_r <= '0;
            lo <= '0;
            hi <= n_last[AW-1:0];
            if (n_sat == '0) begin
              status_r <= LK_EMPTY;
              state <= S_DONE;
            end else begin
              status_r <= LK_MISS;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          mid_r <= mid;
          state <= S_CMP;
        end
        S_CMP: begin
          if (rdata == hash_r) begin
            status_r <= LK_FOUND;
            index_r <= mid_r;
            state <= S_DONE;
          end else if (rdata > hash_r) begin
            if (mid_r != lo) begin
              hi <= mid_r - AW'(1);
              state <= S_READ;
            end else begin
              state <= S_DONE;
            end
          end else begin
            if (mid_r != hi) begin
              lo <= mid_r + AW'(1);
              state <= S_READ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data.hash <= hash_r;
            out_data.index <= index_ext[IDX_W-1:0];
            out_data.status <= status_r;
            out_data.value <= value_r;
            out_last <= line_r;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("search started while busy");

  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (lo <= hi))
    else $error("probe with empty window");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (NW'(mid) < n_sat))
    else $error("probe beyond table size");

  a_deliver: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished lookup not delivered");

endmodule

`default_nettype wire

### rtl/token_hash_dictionary_lookup.sv
`timescale 1ns / 1ps
`default_nettype none

// token hash dictionary lookup
// s_* stream: one beat is a text byte (s_tuser = 0) or a table load (s_tuser = 1)
// text bytes build a token; comma, space, cr and lf end it and start a lookup
// the lookup binary-searches the token's elf hash in the key memory
// loads write one key into the memory and give no result
// m_* stream: one beat per finished token, m_tlast marks a line end
// apb port: register table_size at address 0, pready always high
// text bytes and loads do not stall while no lookup is running
// a token-ending delimiter holds s_tready low while the search makes p probes
// (at most clog2(table_size+1), 7 for 64 keys) and delivers; each probe is
// one key memory read and one compare
// an empty table makes no probe: the search goes from S_IDLE straight to S_DONE
// the result is shown in the cycle in which s_tready returns
// the output register holds one result; while it is not taken, bytes and loads
// are still accepted, but the next lookup's result waits for the register to drain
// reset (rst, synchronous) clears the token state, table_size and the output;
// the key memory is not cleared and must be loaded before it is searched

module token_hash_dictionary_lookup import thdl_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // data_byte[7:0], entry_slot[13:8], entry_key[41:14], zero fill
  input  wire logic [47:0] s_tdata,
  // mode[0]
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // token_hash[27:0], match_index[33:28], lookup_status[35:34],
  // number_value[67:36], zero fill
  output logic      [71:0] m_tdata,
  // line_end
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = (AW + 1 > 7) ? AW + 1 : 7;

  logic [6:0] table_size;

  logic             accept;
  logic             mode;
  logic [7:0]       data_byte;
  logic [5:0]       entry_slot;
  logic [KEY_W-1:0] entry_key;
  logic             is_delim;
  logic             is_eol;
  logic             byte_en;
  logic             delim_en;
  logic             start;
  logic [NW-1:0]    slot_ext;
  logic             wr_en;
  logic             busy;
  token_t           tok;
  result_t          res;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_TABLE_SIZE) ? {25'd0, table_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (psel && penable && pwrite && pready) begin
      table_size <= pwdata[6:0];
    end
  end

  always_comb begin
    mode = s_tuser[0];
    data_byte = s_tdata[7:0];
    entry_slot = s_tdata[13:8];
    entry_key = s_tdata[41:14];
    accept = s_tvalid && s_tready;
    is_delim = data_byte inside {CH_COMMA, CH_SPACE, CH_CR, CH_LF};
    is_eol = data_byte inside {CH_CR, CH_LF};
    byte_en = accept && !mode && !is_delim;
    delim_en = accept && !mode && is_delim;
    start = delim_en && tok.in_token;
    slot_ext = NW'(entry_slot);
    wr_en = accept && mode && (slot_ext < NW'(TABLE_DEPTH));
    s_tready = !busy;
    m_tdata = {4'd0, res.value, res.status, res.index, res.hash};
  end

  thdl_token u_token (
    .clk      (clk),
    .rst      (rst),
    .byte_en  (byte_en),
    .clear    (delim_en),
    .data_byte(data_byte),
    .tok      (tok)
  );

  thdl_search #(
    .DEPTH(TABLE_DEPTH)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .tok       (tok),
    .line_in   (is_eol),
    .table_size(table_size),
    .wr_en     (wr_en),
    .wr_addr   (slot_ext[AW-1:0]),
    .wr_key    (entry_key),
    .busy      (busy),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire
